// ===== sv/rpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared widths, sizes, codes and types for the frontier tracker.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam int MAX_N       = 1024;
  localparam int VAL_W       = 11;
  localparam int CNT_W       = 10;
  localparam int FRONT_CAP   = MAX_N / 2;
  localparam int FRONT_DEPTH = FRONT_CAP + 2;
  localparam int FADDR_W     = $clog2(FRONT_DEPTH);
  localparam int LEAF_LVL    = $clog2(MAX_N);
  localparam int LEAVES      = 1 << LEAF_LVL;
  localparam int TREE_DEPTH  = 2 * LEAVES;
  localparam int NODE_W      = $clog2(TREE_DEPTH);
  localparam int LVL_W       = $clog2(LEAF_LVL + 1);
  localparam int APB_AW      = 3;

  localparam logic [VAL_W-1:0] RESET_INF = VAL_W'(MAX_N + 1);

  // config register indexes
  localparam logic REG_PERM_LEN = 1'b0;

  // tree operations
  localparam logic [1:0] OP_ROOT  = 2'd0;
  localparam logic [1:0] OP_SEEK  = 2'd1;
  localparam logic [1:0] OP_WIPE  = 2'd2;
  localparam logic [1:0] OP_PLACE = 2'd3;

  typedef struct packed {
    logic             clr;
    logic [VAL_W-1:0] mn;
  } node_t;

  typedef struct packed {
    logic             go;
    logic [1:0]       op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] inf;
  } tree_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] z;
  } tree_rsp_t;

endpackage

// ===== sv/rpf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_in_if
// Input item channel: start flag and permutation value.
// ----------------------------------------------------------------------------
interface rpf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      start_req;
  logic [rpf_pkg::VAL_W-1:0] value;

  modport source (output valid, start_req, value, input ready);
  modport sink (input valid, start_req, value, output ready);
endinterface

// ===== sv/rpf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_out_if
// Result item channel: frontier length and status flags.
// ----------------------------------------------------------------------------
interface rpf_out_if;
  logic                      valid;
  logic                      ready;
  logic [rpf_pkg::CNT_W-1:0] frontier_length;
  logic                      grew;
  logic                      rejected;

  modport source (output valid, frontier_length, grew, rejected, input ready);
  modport sink (input valid, frontier_length, grew, rejected, output ready);
endinterface

// ===== sv/rpf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rpf_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_tree
// Lazily cleared min segment tree in one RAM; walks nodes one at a time.
// ----------------------------------------------------------------------------
module rpf_tree (
  input  logic               clk,
  input  logic               rst,
  input  rpf_pkg::tree_cmd_t cmd,
  output rpf_pkg::tree_rsp_t rsp
);
  import rpf_pkg::*;

  localparam logic [3:0] E_CLR   = 4'd0;
  localparam logic [3:0] E_IDLE  = 4'd1;
  localparam logic [3:0] E_ENTER = 4'd2;
  localparam logic [3:0] E_RD    = 4'd3;
  localparam logic [3:0] E_SP1   = 4'd4;
  localparam logic [3:0] E_SP2   = 4'd5;
  localparam logic [3:0] E_DOWN  = 4'd6;
  localparam logic [3:0] E_RET   = 4'd7;
  localparam logic [3:0] E_G0    = 4'd8;
  localparam logic [3:0] E_G1    = 4'd9;
  localparam logic [3:0] E_G2    = 4'd10;
  localparam logic [3:0] E_FIN   = 4'd11;

  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(TREE_DEPTH - 1);
  localparam logic [LVL_W-1:0]  LEAF_AT   = LVL_W'(LEAF_LVL);

  logic [3:0]        state, state_next;
  logic [1:0]        mode;
  logic [NODE_W-1:0] k, clr_addr;
  logic [VAL_W-1:0]  lo, a, b, v, inf, z, rmin, lmin;
  logic [LVL_W-1:0]  lvl;

  logic              we;
  logic [NODE_W-1:0] waddr, raddr;
  node_t             wdata, rdata;

  logic [VAL_W-1:0]  size, half, hi, mid;
  logic [NODE_W-1:0] k_left, k_right, k_up;
  logic              go_ok;

  assign size    = VAL_W'(LEAVES) >> lvl;
  assign half    = size >> 1;
  assign hi      = lo + size - VAL_W'(1);
  assign mid     = lo + half - VAL_W'(1);
  assign k_left  = {k[NODE_W-2:0], 1'b0};
  assign k_right = {k[NODE_W-2:0], 1'b1};
  assign k_up    = {1'b0, k[NODE_W-1:1]};
  assign go_ok   = cmd.go && (state == E_IDLE || state == E_FIN);

  rpf_ram #(.WIDTH($bits(node_t)), .DEPTH(TREE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = k;
    wdata      = '{clr: 1'b1, mn: inf};
    raddr      = k;
    unique case (state) inside
      E_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '{clr: 1'b0, mn: RESET_INF};
        if (clr_addr == LAST_NODE) state_next = E_IDLE;
      end
      E_IDLE, E_FIN: begin
        state_next = E_IDLE;
        if (go_ok) begin
          if (cmd.op == OP_ROOT) begin
            we    = 1'b1;
            waddr = ROOT_NODE;
            wdata = '{clr: 1'b1, mn: cmd.inf};
          end else begin
            state_next = E_ENTER;
          end
        end
      end
      E_ENTER: begin
        unique case (mode)
          OP_SEEK: state_next = (hi <= a) ? E_RET : E_RD;
          OP_WIPE: begin
            if (b < lo || hi < a) begin
              state_next = E_RET;
            end else if (a <= lo && hi <= b) begin
              we         = 1'b1;
              state_next = E_RET;
            end else begin
              state_next = E_RD;
            end
          end
          default: begin
            if (lvl == LEAF_AT) begin
              we         = 1'b1;
              wdata      = '{clr: 1'b0, mn: v};
              state_next = E_RET;
            end else begin
              state_next = E_RD;
            end
          end
        endcase
      end
      E_RD: begin
        if (mode == OP_SEEK && rdata.mn >= a) begin
          state_next = E_RET;
        end else if (mode == OP_SEEK && lvl == LEAF_AT) begin
          state_next = E_FIN;
        end else if (rdata.clr) begin
          we         = 1'b1;
          waddr      = k_left;
          state_next = E_SP1;
        end else begin
          state_next = E_DOWN;
        end
      end
      E_SP1: begin
        we         = 1'b1;
        waddr      = k_right;
        state_next = E_SP2;
      end
      E_SP2: begin
        we         = 1'b1;
        wdata      = '{clr: 1'b0, mn: rmin};
        state_next = E_DOWN;
      end
      E_DOWN: state_next = E_ENTER;
      E_RET: begin
        if (k == ROOT_NODE) begin
          state_next = E_FIN;
        end else if (mode == OP_PLACE) begin
          state_next = E_G0;
        end else if (!k[0]) begin
          state_next = E_ENTER;
        end else begin
          state_next = (mode == OP_SEEK) ? E_RET : E_G0;
        end
      end
      E_G0: begin
        raddr      = k_left;
        state_next = E_G1;
      end
      E_G1: begin
        raddr      = k_right;
        state_next = E_G2;
      end
      E_G2: begin
        we         = 1'b1;
        wdata      = '{clr: 1'b0, mn: (lmin < rdata.mn) ? lmin : rdata.mn};
        state_next = E_RET;
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_CLR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == E_CLR) clr_addr <= clr_addr + NODE_W'(1);
    end
    case (state)
      E_IDLE, E_FIN: begin
        if (go_ok) begin
          mode <= cmd.op;
          a    <= cmd.a;
          b    <= cmd.b;
          v    <= cmd.v;
          inf  <= cmd.inf;
          k    <= ROOT_NODE;
          lo   <= VAL_W'(1);
          lvl  <= '0;
          z    <= '0;
        end
      end
      E_RD: begin
        rmin <= rdata.mn;
        if (mode == OP_SEEK && rdata.mn < a && lvl == LEAF_AT) z <= lo;
      end
      E_DOWN: begin
        lvl <= lvl + LVL_W'(1);
        if (mode == OP_PLACE && a > mid) begin
          k  <= k_right;
          lo <= lo + half;
        end else begin
          k <= k_left;
        end
      end
      E_RET: begin
        if (k != ROOT_NODE) begin
          if (mode == OP_PLACE) begin
            k   <= k_up;
            lvl <= lvl - LVL_W'(1);
          end else if (!k[0]) begin
            k  <= k + NODE_W'(1);
            lo <= lo + size;
          end else begin
            k   <= k_up;
            lvl <= lvl - LVL_W'(1);
            lo  <= lo - size;
          end
        end
      end
      E_G1: lmin <= rdata.mn;
      default: ;
    endcase
  end

  assign rsp.busy = (state == E_CLR);
  assign rsp.done = (state == E_FIN);
  assign rsp.z    = z;

endmodule

// ===== sv/repeated_pattern_frontier_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeated_pattern_frontier_dp
// Frontier tracker over a stream of permutation values.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries one permutation value per item plus start_req, which resets
//  the frontier and the tree before that value is handled. out_ch returns one
//  result item per input item: frontier length, grew and rejected.
//  perm_length (APB register 0) sets n; values 0 or above n are rejected,
//  as is a value equal to its frontier slot entry.
//  One item is worked on at a time. The binary search over the frontier RAM
//  takes a read and a compare per step (T_BS, T_BSW), then the tree walks
//  read each node visited (with an optional lazy push of three writes) and
//  rebuild each node on the way up (E_G0, E_G1, E_G2) through one RAM port.
//  Reset: the tree RAM is swept once over all 2048 nodes, one node per cycle;
//  in_ch.ready stays low until the sweep ends. APB writes are taken always.
//  Stall: a finished result sits in the output register; the next item is
//  accepted meanwhile and waits at its end until that register frees up.
// ----------------------------------------------------------------------------
module repeated_pattern_frontier_dp (
  input  logic                         clk,
  input  logic                         rst,
  rpf_in_if.sink                       in_ch,
  rpf_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpf_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rpf_pkg::*;

  localparam logic [3:0] T_INIT  = 4'd0;
  localparam logic [3:0] T_IDLE  = 4'd1;
  localparam logic [3:0] T_CHK   = 4'd2;
  localparam logic [3:0] T_BS    = 4'd3;
  localparam logic [3:0] T_BSW   = 4'd4;
  localparam logic [3:0] T_RGT   = 4'd5;
  localparam logic [3:0] T_SEEK  = 4'd6;
  localparam logic [3:0] T_WIPE  = 4'd7;
  localparam logic [3:0] T_FWR   = 4'd8;
  localparam logic [3:0] T_FGR   = 4'd9;
  localparam logic [3:0] T_PLACE = 4'd10;
  localparam logic [3:0] T_DONE  = 4'd11;

  localparam logic [VAL_W-1:0]   N_MAX   = VAL_W'(MAX_N);
  localparam logic [CNT_W-1:0]   CAP     = CNT_W'(FRONT_CAP);
  localparam logic [FADDR_W-1:0] F_FIRST = FADDR_W'(1);

  logic [3:0]         state, state_next;
  logic [VAL_W-1:0]   perm_length, n_eff, inf;
  logic [CNT_W-1:0]   count;
  logic [VAL_W-1:0]   y, flo, right, z_r;
  logic [FADDR_W-1:0] lo_b, hi_b, mid, lo_p1, cnt_p1;
  logic [FADDR_W:0]   mid_sum;
  logic               grew_r, rej_r, out_valid;
  logic               accept, cfg_wr, searching, grow;

  logic               f_we;
  logic [FADDR_W-1:0] f_waddr, f_raddr;
  logic [VAL_W-1:0]   f_wdata, f_rdata;

  tree_cmd_t          tr_cmd;
  tree_rsp_t          tr_rsp;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[APB_AW-1] == REG_PERM_LEN) ? {{(32 - VAL_W){1'b0}}, perm_length}
                                                      : 32'd0;

  // effective n clamps to 1..MAX_N; infinity sits one above it
  assign n_eff = (perm_length == '0) ? VAL_W'(1)
               : (perm_length > N_MAX) ? N_MAX : perm_length;
  assign inf   = n_eff + VAL_W'(1);

  assign accept  = in_ch.valid && in_ch.ready;
  assign mid_sum = {1'b0, lo_b} + {1'b0, hi_b};
  assign mid     = mid_sum[FADDR_W:1];
  assign lo_p1   = lo_b + FADDR_W'(1);
  assign cnt_p1  = FADDR_W'(count) + FADDR_W'(1);
  assign searching = ({1'b0, lo_b} + (FADDR_W + 1)'(1)) < {1'b0, hi_b};
  // slot is the last one and the frontier still has room
  assign grow    = (CNT_W'(lo_b) == count) && (count < CAP);

  rpf_ram #(.WIDTH(VAL_W), .DEPTH(FRONT_DEPTH)) u_front (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  rpf_tree u_tree (
    .clk (clk),
    .rst (rst),
    .cmd (tr_cmd),
    .rsp (tr_rsp)
  );

  // ---- sequencer: next state, frontier RAM and tree commands ----
  always_comb begin
    state_next = state;
    f_we       = 1'b0;
    f_waddr    = F_FIRST;
    f_wdata    = inf;
    f_raddr    = mid;
    tr_cmd     = '{go: 1'b0, op: OP_PLACE, a: y, b: right - VAL_W'(1),
                   v: flo, inf: inf};
    unique case (state)
      T_INIT: begin
        f_we    = 1'b1;
        f_wdata = RESET_INF;
        if (!tr_rsp.busy) state_next = T_IDLE;
      end
      T_IDLE: begin
        if (accept) begin
          state_next = T_CHK;
          if (in_ch.start_req) begin
            f_we      = 1'b1;
            tr_cmd.go = 1'b1;
            tr_cmd.op = OP_ROOT;
          end
        end
      end
      T_CHK: state_next = (y == '0 || y > n_eff) ? T_DONE : T_BS;
      T_BS: begin
        if (searching) begin
          state_next = T_BSW;
        end else begin
          f_raddr    = lo_p1;
          state_next = T_RGT;
        end
      end
      T_BSW: state_next = T_BS;
      T_RGT: begin
        if (f_rdata == y) begin
          state_next = T_DONE;
        end else begin
          tr_cmd.go  = 1'b1;
          tr_cmd.op  = OP_SEEK;
          state_next = T_SEEK;
        end
      end
      T_SEEK: begin
        if (tr_rsp.done) begin
          tr_cmd.go = 1'b1;
          if (tr_rsp.z != '0) begin
            tr_cmd.op  = OP_WIPE;
            tr_cmd.a   = tr_rsp.z;
            state_next = T_WIPE;
          end else begin
            state_next = T_PLACE;
          end
        end
      end
      T_WIPE: if (tr_rsp.done) state_next = T_FWR;
      T_FWR: begin
        f_we    = 1'b1;
        f_waddr = lo_p1;
        f_wdata = z_r;
        if (grow) begin
          state_next = T_FGR;
        end else begin
          tr_cmd.go  = 1'b1;
          state_next = T_PLACE;
        end
      end
      T_FGR: begin
        // count already bumped: write the new infinity sentinel
        f_we       = 1'b1;
        f_waddr    = cnt_p1;
        tr_cmd.go  = 1'b1;
        state_next = T_PLACE;
      end
      T_PLACE: if (tr_rsp.done) state_next = T_DONE;
      T_DONE: if (!out_valid || out_ch.ready) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_INIT;
      perm_length <= VAL_W'(1024);
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr && paddr[APB_AW-1] == REG_PERM_LEN) perm_length <= pwdata[VAL_W-1:0];
      if (state == T_IDLE && accept && in_ch.start_req) count <= '0;
      if (state == T_FWR && grow) count <= count + CNT_W'(1);
      // a new result may replace one leaving in the same cycle
      if (state == T_DONE && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
    end
    unique case (state)
      T_IDLE: begin
        y      <= in_ch.value;
        grew_r <= 1'b0;
        rej_r  <= 1'b0;
      end
      T_CHK: begin
        rej_r <= (y == '0 || y > n_eff);
        lo_b  <= '0;
        hi_b  <= cnt_p1;
        flo   <= '0;
      end
      T_BSW: begin
        if (f_rdata < y) begin
          lo_b <= mid;
          flo  <= f_rdata;
        end else begin
          hi_b <= mid;
        end
      end
      T_RGT: begin
        right <= f_rdata;
        rej_r <= (f_rdata == y);
      end
      T_SEEK: begin
        if (tr_rsp.done) begin
          z_r    <= tr_rsp.z;
          grew_r <= (tr_rsp.z != '0);
        end
      end
      T_DONE: begin
        if (!out_valid || out_ch.ready) begin
          out_ch.frontier_length <= count;
          out_ch.grew            <= grew_r;
          out_ch.rejected        <= rej_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state == T_IDLE);
  assign out_ch.valid = out_valid;

  // ---- checks ----
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP) else $error("frontier count above capacity");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.start_req) |=> (count == '0))
    else $error("start request did not clear count");

  a_ready_tree_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !tr_rsp.busy) else $error("item taken during tree sweep");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    tr_rsp.done |-> (state == T_SEEK || state == T_WIPE || state == T_PLACE))
    else $error("tree finished with no command pending");

endmodule

// ===== tb/rpf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_checker
// Watches the item channels and the APB port, predicts every result item
// of the frontier tracker and compares it field by field in order.
// ----------------------------------------------------------------------------
module rpf_checker
  import rpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  rpf_in_if                 in_ch,
  rpf_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_cnt,
  output int                pending,
  output int                result_cnt
);

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic             grew;
    logic             rejected;
  } frontier_res_t;

  logic [VAL_W-1:0] perm_len;
  logic [VAL_W-1:0] front [0:FRONT_DEPTH-1];
  logic [CNT_W-1:0] front_cnt;
  logic [VAL_W-1:0] node_min [1:TREE_DEPTH-1];
  logic             node_clr [1:TREE_DEPTH-1];

  frontier_res_t expected_q [$];

  function automatic logic [VAL_W-1:0] eff_n();
    logic [VAL_W-1:0] n;
    n = perm_len;
    if (n < VAL_W'(1)) n = VAL_W'(1);
    if (n > VAL_W'(MAX_N)) n = VAL_W'(MAX_N);
    return n;
  endfunction

  function automatic logic [VAL_W-1:0] inf_code();
    return eff_n() + 1'b1;
  endfunction

  function automatic void blank_node(int k);
    node_min[k] = inf_code();
    node_clr[k] = 1'b1;
  endfunction

  function automatic void push_down(int k);
    if (node_clr[k]) begin
      blank_node(2 * k);
      blank_node(2 * k + 1);
      node_clr[k] = 1'b0;
    end
  endfunction

  function automatic void pull_up(int k);
    node_min[k] = (node_min[2*k] < node_min[2*k+1]) ? node_min[2*k] : node_min[2*k+1];
  endfunction

  function automatic void blank_span(int k, int lo, int hi, int a, int b);
    int mid;
    if (b < lo || hi < a) return;
    if (a <= lo && hi <= b) begin
      blank_node(k);
      return;
    end
    push_down(k);
    mid = (lo + hi) / 2;
    blank_span(2 * k, lo, mid, a, b);
    blank_span(2 * k + 1, mid + 1, hi, a, b);
    pull_up(k);
  endfunction

  function automatic void store_leaf(int k, int lo, int hi, int pos, logic [VAL_W-1:0] v);
    int mid;
    if (lo == hi) begin
      node_min[k] = v;
      node_clr[k] = 1'b0;
      return;
    end
    push_down(k);
    mid = (lo + hi) / 2;
    if (pos <= mid) store_leaf(2 * k, lo, mid, pos, v);
    else store_leaf(2 * k + 1, mid + 1, hi, pos, v);
    pull_up(k);
  endfunction

  // first leaf above y whose minimum is below y, 0 if none
  function automatic int find_cover(int k, int lo, int hi, int y);
    int mid, got;
    if (hi <= y || node_min[k] >= y) return 0;
    if (lo == hi) return lo;
    push_down(k);
    mid = (lo + hi) / 2;
    got = find_cover(2 * k, lo, mid, y);
    return (got != 0) ? got : find_cover(2 * k + 1, mid + 1, hi, y);
  endfunction

  function automatic frontier_res_t track_value(logic start, logic [VAL_W-1:0] y);
    frontier_res_t r;
    int lo, hi, mid, j, z;
    logic [VAL_W-1:0] right;
    r = '0;
    if (start) begin
      front[0] = '0;
      front[1] = inf_code();
      front_cnt = '0;
      blank_node(1);
    end
    if (y < 1 || y > eff_n()) begin
      r.len = front_cnt;
      r.rejected = 1'b1;
      return r;
    end
    lo = 0;
    hi = front_cnt + 1;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      if (front[mid] < y) lo = mid;
      else hi = mid;
    end
    j = lo;
    right = front[j+1];
    if (right == y) begin
      r.len = front_cnt;
      r.rejected = 1'b1;
      return r;
    end
    z = find_cover(1, 1, LEAVES, y);
    if (z != 0) begin
      if (right >= 1) blank_span(1, 1, LEAVES, z, right - 1);
      front[j+1] = VAL_W'(z);
      if (j == front_cnt && front_cnt < FRONT_CAP) begin
        front_cnt = front_cnt + 1'b1;
        front[front_cnt+1] = inf_code();
      end
      r.grew = 1'b1;
    end
    store_leaf(1, 1, LEAVES, y, front[j]);
    r.len = front_cnt;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    frontier_res_t e, got;
    if (rst) begin
      perm_len = VAL_W'(MAX_N);
      for (int i = 0; i < FRONT_DEPTH; i++) front[i] = '0;
      front[1] = RESET_INF;
      front_cnt = '0;
      for (int i = 1; i < TREE_DEPTH; i++) begin
        node_min[i] = RESET_INF;
        node_clr[i] = 1'b0;
      end
      expected_q.delete();
      fail_cnt <= 0;
      result_cnt <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == '0)
        perm_len = pwdata[VAL_W-1:0];
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(track_value(in_ch.start_req, in_ch.value));
      if (out_ch.valid && out_ch.ready) begin
        result_cnt <= result_cnt + 1;
        got = '{out_ch.frontier_length, out_ch.grew, out_ch.rejected};
        if (expected_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: result item with none expected: len=%0d grew=%0d rej=%0d",
                     $realtime, got.len, got.grew, got.rejected);
          fail_cnt <= fail_cnt + 1;
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            if (fail_cnt < 10)
              $display("%0t: mismatch exp len=%0d grew=%0d rej=%0d, got len=%0d grew=%0d rej=%0d",
                       $realtime, e.len, e.grew, e.rejected, got.len, got.grew,
                       got.rejected);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the frontier tracker: directed edge cases, then
// random permutations with noise over many perm_length settings.
// ----------------------------------------------------------------------------
module tb;
  import rpf_pkg::*;

  localparam int LIMIT = 20_000_000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  int fail_cnt, pending, result_cnt;
  int cycles;
  int items_sent;
  int phases;
  int ready_hold;
  bit no_idle;   // set for stretches where neither side idles

  rpf_in_if  in_ch ();
  rpf_out_if out_ch ();

  repeated_pattern_frontier_dp i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rpf_checker i_chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_cnt(fail_cnt), .pending(pending), .result_cnt(result_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      ready_hold <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // valid stays high across back-to-back items; only lowered before a gap
  task automatic send_item(bit start, logic [VAL_W-1:0] val);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= start;
    in_ch.value     <= val;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // APB write: setup then access, register taken at the access edge
  task automatic set_perm_len(logic [31:0] n);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_AW'(REG_PERM_LEN) << 2;
    pwdata  <= n;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one shuffled permutation of 1..n, cut at max_items, with some noise:
  // out-of-range values and repeats of earlier values
  task automatic send_perm(int n, int max_items, bit do_start);
    int p[$];
    int k, t, cnt;
    logic [VAL_W-1:0] v;
    for (int i = 1; i <= n; i++) p.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = p[i]; p[i] = p[k]; p[k] = t;
    end
    cnt = (n < max_items) ? n : max_items;
    for (int i = 0; i < cnt; i++) begin
      v = VAL_W'(p[i]);
      case ($urandom_range(0, 99))
        0, 1, 2: v = VAL_W'($urandom_range(0, 2047));
        3, 4:    v = VAL_W'(p[$urandom_range(0, i)]);
        5:       v = '0;
        default: ;
      endcase
      send_item(do_start && i == 0, v);
    end
  endtask

  initial begin
    int n;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.start_req = 1'b0; in_ch.value = '0;
    cycles = 0; items_sent = 0; phases = 0; no_idle = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: straight out of reset with no start, then extremes
    send_item(1'b0, 11'd5);
    send_item(1'b0, 11'd3);
    send_item(1'b0, 11'd7);
    send_item(1'b0, 11'd2);
    send_item(1'b0, 11'd6);
    send_item(1'b0, 11'd6);      // duplicate, may hit a frontier entry
    send_item(1'b0, 11'd0);      // below range
    send_item(1'b0, 11'd1025);   // above n
    send_item(1'b0, 11'd2047);   // all ones
    send_item(1'b0, 11'd1024);   // top leaf
    send_item(1'b1, 11'd1024);   // restart on a valid value
    send_item(1'b0, 11'd1);
    send_item(1'b0, 11'd512);
    send_item(1'b1, 11'd0);      // restart taken even when rejected
    send_item(1'b0, 11'd4);
    drain();
    set_perm_len(32'd1);
    send_item(1'b1, 11'd1);
    send_item(1'b0, 11'd1);
    send_item(1'b0, 11'd2);
    drain();
    set_perm_len(32'd0);         // acts as 1
    send_item(1'b1, 11'd1);
    send_item(1'b0, 11'd2);
    drain();
    set_perm_len(32'h7FF);       // clamps to MAX_N
    send_item(1'b1, 11'd1024);
    send_item(1'b0, 11'd1025);
    send_item(1'b0, 11'd3);
    drain();

    // one long run at the full size, without idling
    set_perm_len(32'd1024);
    no_idle = 1'b1;
    send_perm(1024, 300, 1'b1);
    no_idle = 1'b0;
    drain();

    // random phases, mostly small n; some phases keep state across the write
    while (items_sent < 2000) begin
      phases++;
      case ($urandom_range(0, 19))
        0:       n = 1;
        1:       n = 1024;
        2:       n = 0;
        3:       n = 2047;
        default: n = $urandom_range(2, 64);
      endcase
      set_perm_len(n);
      no_idle = ($urandom_range(0, 4) == 0);
      if (n < 1) n = 1;
      if (n > MAX_N) n = MAX_N;
      repeat ($urandom_range(1, 5))
        send_perm(n, 150, $urandom_range(0, 9) != 0);
      no_idle = 1'b0;
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d items over %0d random phases, %0d results checked.",
             items_sent, phases, result_cnt);
    $display("Covered perm_length 0, 1, small, 1024 and 2047, restarts and rejects.");
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
